// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the running statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside reset
`define RSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that prop never holds outside reset
`define RSA_NEVER(lbl, prop, msg) \
  `RSA_ASSERT(lbl, !(prop), msg)

`endif

// ----- rtl/core/rsa_pkg.sv -----
// Types and constants of the running statistics accumulator
package rsa_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned M2_FRAC  = 8;
  localparam int unsigned M2_W     = 64;
  localparam int unsigned EN_W     = 6;
  localparam int unsigned MEAN_W   = SAMPLE_W + FRAC_W;
  localparam int unsigned M2_SHIFT = 2 * FRAC_W - M2_FRAC;
  localparam int unsigned DIV_W    = M2_W + M2_SHIFT;
  localparam int unsigned ROOT_W   = DIV_W / 2;
  localparam int unsigned SD_W     = 32;

  localparam int unsigned EN_MEAN = 0;
  localparam int unsigned EN_DEV  = 1;
  localparam int unsigned EN_MAX  = 2;
  localparam int unsigned EN_MIN  = 3;
  localparam int unsigned EN_MAXA = 4;
  localparam int unsigned EN_MINA = 5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         sample_total;
    logic signed [MEAN_W-1:0]   mean;
    logic [SD_W-1:0]            stddev;
    logic                       stddev_valid;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0]        max_magnitude;
    logic [SAMPLE_W-1:0]        min_magnitude;
    logic                       count_full;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_start;
    logic div_long;
    logic mean_upd;
    logic mul;
    logic acc;
    logic sqrt_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_mean;
    logic need_sd;
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

// ----- rtl/core/running_statistics_accumulator.sv -----
// Top level of the running statistics accumulator
//
// Input channel: in_valid_i / in_stall_o carry one word per sample (sample,
// start_req). Output channel: out_valid_o / out_stall_i carry one word of
// statistics per sample. A word moves when valid is high and stall is low.
// stat_enable is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, as the block does not enforce this. Samples are
// processed one at a time. An accepted item passes capture and prep, then a
// mean update when one is needed (32-step quotient) and the deviation when
// needed: an 88-step division by n-1 and a 44-step square root, all on one
// radix-2 divider and one bit-serial root unit, before its result is
// loaded into the output register.
// The next sample is accepted as soon as the result is loaded into the
// output register, even while the receiver stalls; a second result waits
// in the controller until the first word is taken.
// Reset clears the run state and sets stat_enable to all ones.
module running_statistics_accumulator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rsa_pkg::EN_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rsa_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rsa_pkg::out_item_t       out_data_o
);
  import rsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  rsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

`include "assert_macros.svh"

  `RSA_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "no stall after accept")
  `RSA_ASSERT(a_sd_needs_two, (out_valid_o && out_data_o.stddev_valid) |-> (out_data_o.sample_total >= COUNT_W'(2)), "stddev valid below two samples")
  `RSA_ASSERT(a_full_count, (out_valid_o && out_data_o.count_full) |-> (&out_data_o.sample_total), "count_full without saturated count")
  `RSA_NEVER(a_div_sqrt_overlap, cmd.div_start && cmd.sqrt_start, "divider and root started together")

endmodule

// ----- rtl/core/rsa_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, short and long modes
module rsa_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        long_i,
  input  logic [rsa_pkg::DIV_W-1:0]   dividend_i,
  input  logic [rsa_pkg::COUNT_W-1:0] divisor_i,
  output logic [rsa_pkg::DIV_W-1:0]   quotient_o,
  output logic                        done_o
);
  import rsa_pkg::*;

  localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
  localparam int unsigned SHORT_W = MEAN_W;

  logic [DIV_W-1:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic [COUNT_W-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [COUNT_W:0]   trial, diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = long_i ? dividend_i : (dividend_i << (DIV_W - SHORT_W));
      quo_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = long_i ? CNT_W'(DIV_W) : CNT_W'(SHORT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dvd_q  <= dvd_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- rtl/core/rsa_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle
module rsa_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsa_pkg::DIV_W-1:0]  radicand_i,
  output logic [rsa_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);
  import rsa_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [DIV_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [REM_W+1:0]  remx, trial, diff;
  logic              ge;

  always_comb begin
    remx  = {rem_q, rad_q[DIV_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = remx - trial;
    ge    = remx >= trial;
    rad_d = rad_q;
    root_d = root_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = CNT_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      root_d = {root_q[ROOT_W-2:0], ge};
      rem_d  = ge ? diff[REM_W-1:0] : remx[REM_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rad_q  <= rad_d;
      root_q <= root_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/rsa_datapath.sv -----
// Datapath: run state, mean and M2 update, extremes, divider and root units
module rsa_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rsa_pkg::EN_W-1:0] cfg_wdata_i,
  input  rsa_pkg::in_item_t        in_data_i,
  input  rsa_pkg::cmd_t            cmd_i,
  output rsa_pkg::status_t         status_o,
  output rsa_pkg::out_item_t       out_data_o
);
  import rsa_pkg::*;

  localparam int unsigned XQ_W  = MEAN_W + 1;
  localparam int unsigned MAG_W = SAMPLE_W + 1;

  logic [EN_W-1:0]            en_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       start_q;
  logic [COUNT_W-1:0]         cnt_q;
  logic signed [MEAN_W-1:0]   mean_q;
  logic [M2_W-1:0]            m2_q;
  logic signed [SAMPLE_W-1:0] max_q, min_q;
  logic [MAG_W-1:0]           maxa_q, mina_q;
  logic                       full_q;
  logic [MEAN_W-1:0]          d1mag_q, d2mag_q;
  logic                       d1neg_q;
  logic [2*MEAN_W-1:0]        prod_q;
  out_item_t                  out_q;

  logic [COUNT_W-1:0]         cnt_eff;
  logic                       is_full, first;
  logic signed [XQ_W-1:0]     xq, d1, d2;
  logic [XQ_W-1:0]            d1n, d2n;
  logic [MAG_W-1:0]           xs, xmag;
  logic [MEAN_W-1:0]          d1mag, d2mag, st;
  logic signed [MEAN_W-1:0]   mnew;
  logic [M2_W:0]              m2_sum;
  logic [DIV_W-1:0]           dividend, quotient;
  logic [COUNT_W-1:0]         divisor;
  logic [ROOT_W-1:0]          root;
  logic [SD_W-1:0]            sd_sat;
  logic                       div_done, sqrt_done, need_sd;

  always_comb begin
    cnt_eff = start_q ? '0 : cnt_q;
    is_full = &cnt_eff;
    first   = cnt_eff == '0;
    xq      = $signed({x_q[SAMPLE_W-1], x_q, {FRAC_W{1'b0}}});
    xs      = {x_q[SAMPLE_W-1], x_q};
    xmag    = x_q[SAMPLE_W-1] ? (MAG_W'(0) - xs) : xs;
    d1      = xq - $signed({mean_q[MEAN_W-1], mean_q});
    d1n     = XQ_W'(0) - d1;
    d1mag   = d1[XQ_W-1] ? d1n[MEAN_W-1:0] : d1[MEAN_W-1:0];
    st      = quotient[MEAN_W-1:0];
    mnew    = d1neg_q ? (mean_q - $signed(st)) : (mean_q + $signed(st));
    d2      = xq - $signed({mnew[MEAN_W-1], mnew});
    d2n     = XQ_W'(0) - d2;
    d2mag   = d2[XQ_W-1] ? d2n[MEAN_W-1:0] : d2[MEAN_W-1:0];
    m2_sum  = {1'b0, m2_q} + (M2_W + 1)'(prod_q[2*MEAN_W-1:M2_SHIFT]);
    dividend = cmd_i.div_long ? {m2_q, {M2_SHIFT{1'b0}}} : DIV_W'(d1mag_q);
    divisor  = cmd_i.div_long ? (cnt_q - COUNT_W'(1)) : cnt_q;
    sd_sat   = (|root[ROOT_W-1:SD_W]) ? '1 : root[SD_W-1:0];
    need_sd  = (cnt_q >= COUNT_W'(2)) && en_q[EN_MEAN] && en_q[EN_DEV];
  end

  rsa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .long_i     (cmd_i.div_long),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  rsa_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (quotient),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '1;
      x_q     <= '0;
      start_q <= 1'b0;
      cnt_q   <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
      max_q   <= '0;
      min_q   <= '0;
      maxa_q  <= '0;
      mina_q  <= '0;
      full_q  <= 1'b0;
      d1mag_q <= '0;
      d2mag_q <= '0;
      d1neg_q <= 1'b0;
      prod_q  <= '0;
      out_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        x_q     <= in_data_i.sample;
        start_q <= in_data_i.start_req;
      end
      if (cmd_i.prep) begin
        full_q  <= is_full;
        d1mag_q <= d1mag;
        d1neg_q <= d1[XQ_W-1];
        if (!is_full) begin
          cnt_q <= cnt_eff + COUNT_W'(1);
          if (first) begin
            if (en_q[EN_MEAN]) begin
              mean_q <= xq[MEAN_W-1:0];
              m2_q   <= '0;
            end
            if (en_q[EN_MAX])  max_q  <= x_q;
            if (en_q[EN_MIN])  min_q  <= x_q;
            if (en_q[EN_MAXA]) maxa_q <= xmag;
            if (en_q[EN_MINA]) mina_q <= xmag;
          end else begin
            if (en_q[EN_MAX] && (x_q > max_q))    max_q  <= x_q;
            if (en_q[EN_MIN] && (x_q < min_q))    min_q  <= x_q;
            if (en_q[EN_MAXA] && (xmag > maxa_q)) maxa_q <= xmag;
            if (en_q[EN_MINA] && (xmag < mina_q)) mina_q <= xmag;
          end
        end
      end
      if (cmd_i.mean_upd) begin
        mean_q  <= mnew;
        d2mag_q <= d2mag;
      end
      if (cmd_i.mul) begin
        prod_q <= d1mag_q * d2mag_q;
      end
      if (cmd_i.acc) begin
        m2_q <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
      end
      if (cmd_i.load_out) begin
        out_q.sample_total  <= cnt_q;
        out_q.mean          <= en_q[EN_MEAN] ? mean_q : '0;
        out_q.stddev        <= need_sd ? sd_sat : '0;
        out_q.stddev_valid  <= need_sd;
        out_q.maximum       <= en_q[EN_MAX] ? max_q : '0;
        out_q.minimum       <= en_q[EN_MIN] ? min_q : '0;
        out_q.max_magnitude <= en_q[EN_MAXA] ? maxa_q[SAMPLE_W-1:0] : '0;
        out_q.min_magnitude <= en_q[EN_MINA] ? mina_q[SAMPLE_W-1:0] : '0;
        out_q.count_full    <= full_q;
      end
    end
  end

  assign status_o.need_mean = !is_full && !first && en_q[EN_MEAN];
  assign status_o.need_sd   = need_sd;
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;
  assign out_data_o         = out_q;

endmodule

// ----- rtl/core/rsa_ctrl.sv -----
// Controller: sequences capture, mean update, deviation and result hand-off
module rsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rsa_pkg::status_t status_i,
  output rsa_pkg::cmd_t    cmd_o
);
  import rsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MDIV, S_MWAIT, S_MFIN, S_MMUL, S_MACC,
    S_STAT, S_SDIV, S_SWAIT, S_SQRT, S_QWAIT, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  always_comb begin
    can_load    = !out_valid_q || !out_stall_i;
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = status_i.need_mean ? S_MDIV : S_STAT;
      end
      S_MDIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (status_i.div_done) state_d = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.mean_upd = 1'b1;
        state_d = S_MMUL;
      end
      S_MMUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_MACC;
      end
      S_MACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_STAT;
      end
      S_STAT: begin
        state_d = status_i.need_sd ? S_SDIV : S_FIN;
      end
      S_SDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_long  = 1'b1;
        state_d = S_SWAIT;
      end
      S_SWAIT: begin
        cmd_o.div_long = 1'b1;
        if (status_i.div_done) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_QWAIT;
      end
      S_QWAIT: begin
        if (status_i.sqrt_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (can_load) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- tb/running_statistics_accumulator_tb.sv -----
// Testbench for the running statistics accumulator: predicts every result word and checks it
module running_statistics_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [EN_W-1:0] EN_ALL = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  class stats_scoreboard;
    logic [EN_W-1:0]    enable;
    logic [COUNT_W-1:0] count;
    logic signed [63:0] mean_q;
    logic [63:0]        m2;
    logic signed [63:0] max_s, min_s;
    logic [63:0]        max_a, min_a;
    out_item_t          pending[$];
    int unsigned        failures;
    int unsigned        checked;

    function void clear();
      enable = EN_ALL;
      count = '0;
      mean_q = '0;
      m2 = '0;
      max_s = '0;
      min_s = '0;
      max_a = '0;
      min_a = '0;
      failures = 0;
      checked = 0;
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function void note_input(in_item_t it);
      logic signed [63:0] x, xq, d1, d2, mnew;
      logic [63:0] a, st, sum, root, t;
      logic [127:0] prod, num, q;
      out_item_t o;
      x = it.sample;
      a = mag(x);
      o = '0;
      if (it.start_req) count = '0;
      if (count == COUNT_MAX) begin
        o.count_full = 1'b1;
      end else begin
        count++;
        if (count == 1) begin
          if (enable[EN_MEAN]) begin
            mean_q = x <<< FRAC_W;
            m2 = '0;
          end
          if (enable[EN_MAX]) max_s = x;
          if (enable[EN_MIN]) min_s = x;
          if (enable[EN_MAXA]) max_a = a;
          if (enable[EN_MINA]) min_a = a;
        end else begin
          if (enable[EN_MEAN]) begin
            xq = x <<< FRAC_W;
            d1 = xq - mean_q;
            st = mag(d1) / {40'b0, count};
            mnew = d1 < 0 ? mean_q - $signed(st) : mean_q + $signed(st);
            d2 = xq - mnew;
            prod = {64'b0, mag(d1)} * {64'b0, mag(d2)};
            prod = prod >> M2_SHIFT;
            sum = m2 + prod[63:0];
            if (prod[127:64] != 0 || sum < m2) m2 = '1;
            else m2 = sum;
            mean_q = mnew;
          end
          if (enable[EN_MAX] && x > max_s) max_s = x;
          if (enable[EN_MIN] && x < min_s) min_s = x;
          if (enable[EN_MAXA] && a > max_a) max_a = a;
          if (enable[EN_MINA] && a < min_a) min_a = a;
        end
      end
      if (count >= 2 && enable[EN_MEAN] && enable[EN_DEV]) begin
        num = {64'b0, m2} << M2_SHIFT;
        q = num / {104'b0, count - 24'd1};
        root = '0;
        for (int b = 63; b >= 0; b--) begin
          t = root | (64'd1 << b);
          if ({64'b0, t} * {64'b0, t} <= q) root = t;
        end
        o.stddev = root > 64'hFFFF_FFFF ? '1 : root[31:0];
        o.stddev_valid = 1'b1;
      end
      o.sample_total = count;
      o.mean = enable[EN_MEAN] ? mean_q[31:0] : '0;
      o.maximum = enable[EN_MAX] ? max_s[15:0] : '0;
      o.minimum = enable[EN_MIN] ? min_s[15:0] : '0;
      o.max_magnitude = enable[EN_MAXA] ? max_a[15:0] : '0;
      o.min_magnitude = enable[EN_MINA] ? min_a[15:0] : '0;
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        failures++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.sample_total !== e.sample_total) begin
        $error("sample_total: expected %0d, got %0d", e.sample_total, got.sample_total);
        failures++;
      end
      if (got.mean !== e.mean) begin
        $error("mean: expected %h, got %h", e.mean, got.mean);
        failures++;
      end
      if (got.stddev !== e.stddev) begin
        $error("stddev: expected %h, got %h", e.stddev, got.stddev);
        failures++;
      end
      if (got.stddev_valid !== e.stddev_valid) begin
        $error("stddev_valid: expected %b, got %b", e.stddev_valid, got.stddev_valid);
        failures++;
      end
      if (got.maximum !== e.maximum) begin
        $error("maximum: expected %0d, got %0d", e.maximum, got.maximum);
        failures++;
      end
      if (got.minimum !== e.minimum) begin
        $error("minimum: expected %0d, got %0d", e.minimum, got.minimum);
        failures++;
      end
      if (got.max_magnitude !== e.max_magnitude) begin
        $error("max_magnitude: expected %0d, got %0d", e.max_magnitude, got.max_magnitude);
        failures++;
      end
      if (got.min_magnitude !== e.min_magnitude) begin
        $error("min_magnitude: expected %0d, got %0d", e.min_magnitude, got.min_magnitude);
        failures++;
      end
      if (got.count_full !== e.count_full) begin
        $error("count_full: expected %b, got %b", e.count_full, got.count_full);
        failures++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [EN_W-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_data_o;

  stats_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycles;
  int unsigned     sent;

  running_statistics_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_enable(logic [EN_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.enable = value;
  endtask

  task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic st);
    in_item_t it;
    it.sample = s;
    it.start_req = st;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int unsigned idle, int unsigned stall,
                              logic [EN_W-1:0] en);
    logic signed [SAMPLE_W-1:0] s;
    int unsigned pick;
    idle_pct = idle;
    stall_pct = stall;
    write_enable(en);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else if (pick < 40) s = $signed(16'($urandom_range(200))) - 16'sd100;
      else s = 16'($urandom);
      send_word(s, $urandom_range(29) == 0);
    end
    drain();
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sd5, 1'b1);
    send_word(16'sd5, 1'b0);
    send_word(16'sd5, 1'b0);
    drain();
    write_enable('0);
    send_word(16'sd300, 1'b0);
    send_word(-16'sd300, 1'b1);
    drain();
    write_enable(6'b000001);
    send_word(16'sd77, 1'b0);
    send_word(-16'sd9, 1'b0);
    drain();
    write_enable(6'b000010);
    send_word(16'sd12, 1'b1);
    send_word(16'sd13, 1'b0);
    drain();
    write_enable(EN_ALL);
    send_word(16'sd1000, 1'b0);
    send_word(-16'sd1000, 1'b0);
    drain();

    random_phase(300, 0, 0, EN_ALL);
    random_phase(250, 69, 0, 6'($urandom));
    random_phase(250, 0, 69, EN_ALL);
    random_phase(150, 12, 12, 6'b110101);
    random_phase(100, 69, 69, 6'($urandom));
    random_phase(80, 12, 12, '0);
    random_phase(50, 0, 0, EN_ALL);

    $display("Sent %0d samples and checked %0d result words over several enable masks,",
             sent, sb.checked);
    $display("with run restarts, extreme samples and sender/receiver idling mixes.");
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rsa_pkg.sv
rtl/core/rsa_divider.sv
rtl/core/rsa_sqrt.sv
rtl/core/rsa_datapath.sv
rtl/core/rsa_ctrl.sv
rtl/core/running_statistics_accumulator.sv
tb/running_statistics_accumulator_tb.sv
